### rtl/crc8fr_pkg.sv
// Package for the CRC-8 frame receiver: shared widths, phase and sequencer
// encodings, register indexes, frame descriptor and the CRC-8 update.
// No dependencies.
`timescale 1ns / 1ps

package crc8fr_pkg;

  localparam int BYTE_W      = 8;
  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = 6;
  localparam int LEN_W       = 8;
  localparam int CNT_W       = 7;
  localparam int CFG_IDX_W   = 2;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [BYTE_W-1:0] VERSION_RST     = 8'h01;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd2;

  typedef enum logic [2:0] {
    PH_SYNC_A,
    PH_SYNC_B,
    PH_VERSION,
    PH_TYPE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CHECK
  } rx_phase_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_SHOW
  } em_state_t;

  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] kind;
    logic [CNT_W-1:0]  length;
    logic [CNT_W-1:0]  count;
  } frame_desc_t;

  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### rtl/crc8fr_ram.sv
// Payload store: 64 x 8 synchronous memory, one write and one read port,
// registered read data. Depends on crc8fr_pkg.
`timescale 1ns / 1ps

module crc8fr_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [crc8fr_pkg::STORE_AW-1:0] wr_addr,
  input  logic [crc8fr_pkg::BYTE_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [crc8fr_pkg::STORE_AW-1:0] rd_addr,
  output logic [crc8fr_pkg::BYTE_W-1:0]   rd_data
);

  logic [crc8fr_pkg::BYTE_W-1:0] mem_r [crc8fr_pkg::STORE_DEPTH];
  logic [crc8fr_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/crc8fr_parser.sv
// Receive side: sync hunt, header decode, running CRC, payload writes to the
// store and the frame descriptor for the emitter. Depends on crc8fr_pkg.
`timescale 1ns / 1ps

module crc8fr_parser #(
  parameter int MAX_PAYLOAD_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [crc8fr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crc8fr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                            in_fire,
  input  logic [crc8fr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                            wr_en,
  output logic [crc8fr_pkg::STORE_AW-1:0]  wr_addr,
  output logic [crc8fr_pkg::BYTE_W-1:0]    wr_data,
  output crc8fr_pkg::frame_desc_t         frm
);

  crc8fr_pkg::rx_phase_t phase_r, phase_nxt;
  logic [crc8fr_pkg::BYTE_W-1:0] sync_first_r, sync_second_r, version_r;
  logic [crc8fr_pkg::BYTE_W-1:0] kind_r, kind_nxt;
  logic [crc8fr_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [crc8fr_pkg::CNT_W-1:0]  rcnt_r, rcnt_nxt;
  logic [crc8fr_pkg::BYTE_W-1:0] crc_r, crc_nxt;
  logic [crc8fr_pkg::BYTE_W-1:0] crc_step;
  logic [crc8fr_pkg::CNT_W-1:0]  rcnt_inc;
  logic [2*crc8fr_pkg::BYTE_W-1:0] full_len;

  assign crc_step = crc8fr_pkg::crc8_update(crc_r, in_rx_byte);
  assign rcnt_inc = rcnt_r + crc8fr_pkg::CNT_W'(1);
  assign full_len = {in_rx_byte, len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= crc8fr_pkg::SYNC_FIRST_RST;
      sync_second_r <= crc8fr_pkg::SYNC_SECOND_RST;
      version_r     <= crc8fr_pkg::VERSION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        crc8fr_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        crc8fr_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        crc8fr_pkg::CFG_VERSION:     version_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= crc8fr_pkg::PH_SYNC_A;
      kind_r  <= '0;
      len_r   <= '0;
      rcnt_r  <= '0;
      crc_r   <= crc8fr_pkg::CRC_INIT;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      rcnt_r  <= rcnt_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    rcnt_nxt  = rcnt_r;
    crc_nxt   = crc_r;
    case (phase_r)
      crc8fr_pkg::PH_SYNC_A: begin
        if (in_rx_byte == sync_first_r) phase_nxt = crc8fr_pkg::PH_SYNC_B;
      end
      crc8fr_pkg::PH_SYNC_B: begin
        if (in_rx_byte == sync_second_r) begin
          phase_nxt = crc8fr_pkg::PH_VERSION;
          crc_nxt   = crc8fr_pkg::CRC_INIT;
        end else if (in_rx_byte == sync_first_r) begin
          phase_nxt = crc8fr_pkg::PH_SYNC_B;
        end else begin
          phase_nxt = crc8fr_pkg::PH_SYNC_A;
        end
      end
      crc8fr_pkg::PH_VERSION: begin
        if (in_rx_byte != version_r) begin
          phase_nxt = crc8fr_pkg::PH_SYNC_A;
          len_nxt   = '0;
          rcnt_nxt  = '0;
          crc_nxt   = crc8fr_pkg::CRC_INIT;
        end else begin
          phase_nxt = crc8fr_pkg::PH_TYPE;
          crc_nxt   = crc_step;
        end
      end
      crc8fr_pkg::PH_TYPE: begin
        kind_nxt  = in_rx_byte;
        crc_nxt   = crc_step;
        phase_nxt = crc8fr_pkg::PH_LEN_LO;
      end
      crc8fr_pkg::PH_LEN_LO: begin
        len_nxt   = in_rx_byte;
        crc_nxt   = crc_step;
        phase_nxt = crc8fr_pkg::PH_LEN_HI;
      end
      crc8fr_pkg::PH_LEN_HI: begin
        rcnt_nxt = '0;
        if (full_len > (2*crc8fr_pkg::BYTE_W)'(MAX_PAYLOAD_BYTES)) begin
          phase_nxt = crc8fr_pkg::PH_SYNC_A;
          len_nxt   = '0;
          crc_nxt   = crc8fr_pkg::CRC_INIT;
        end else begin
          crc_nxt   = crc_step;
          phase_nxt = (len_r == '0) ? crc8fr_pkg::PH_CHECK : crc8fr_pkg::PH_PAYLOAD;
        end
      end
      crc8fr_pkg::PH_PAYLOAD: begin
        rcnt_nxt = rcnt_inc;
        crc_nxt  = crc_step;
        if ({1'b0, rcnt_inc} >= len_r) phase_nxt = crc8fr_pkg::PH_CHECK;
      end
      crc8fr_pkg::PH_CHECK: begin
        phase_nxt = crc8fr_pkg::PH_SYNC_A;
        len_nxt   = '0;
        rcnt_nxt  = '0;
        crc_nxt   = crc8fr_pkg::CRC_INIT;
      end
      default: phase_nxt = crc8fr_pkg::PH_SYNC_A;
    endcase
  end

  // outputs
  always_comb begin
    wr_en      = in_fire && (phase_r == crc8fr_pkg::PH_PAYLOAD);
    wr_addr    = rcnt_r[crc8fr_pkg::STORE_AW-1:0];
    wr_data    = in_rx_byte;
    frm.start  = in_fire && (phase_r == crc8fr_pkg::PH_CHECK) && (in_rx_byte == crc_r);
    frm.kind   = kind_r;
    frm.length = len_r[crc8fr_pkg::CNT_W-1:0];
    frm.count  = (len_r > crc8fr_pkg::LEN_W'(crc8fr_pkg::STORE_DEPTH)) ?
                 crc8fr_pkg::CNT_W'(crc8fr_pkg::STORE_DEPTH) : len_r[crc8fr_pkg::CNT_W-1:0];
  end

endmodule

### rtl/crc8fr_emitter.sv
// Result sequencer: reads the payload store one entry per payload result and holds
// each result in the output register until taken. Depends on crc8fr_pkg.
`timescale 1ns / 1ps

module crc8fr_emitter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  crc8fr_pkg::frame_desc_t        frm,
  output logic                           idle,
  output logic                           rd_en,
  output logic [crc8fr_pkg::STORE_AW-1:0] rd_addr,
  input  logic [crc8fr_pkg::BYTE_W-1:0]   rd_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crc8fr_pkg::BYTE_W-1:0]   out_frame_type,
  output logic [crc8fr_pkg::CNT_W-1:0]    out_frame_length,
  output logic [crc8fr_pkg::STORE_AW-1:0] out_byte_index,
  output logic [crc8fr_pkg::BYTE_W-1:0]   out_payload_byte,
  output logic                           out_has_payload,
  output logic                           out_last
);

  crc8fr_pkg::em_state_t state_r, state_nxt;
  logic [crc8fr_pkg::STORE_AW-1:0] idx_r;
  logic [crc8fr_pkg::CNT_W-1:0]    cnt_r;
  logic [crc8fr_pkg::CNT_W-1:0]    len_r;
  logic [crc8fr_pkg::BYTE_W-1:0]   kind_r;
  logic                            empty_r;
  logic                            is_last;

  assign is_last = empty_r ||
                   ((crc8fr_pkg::CNT_W'(idx_r) + crc8fr_pkg::CNT_W'(1)) == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crc8fr_pkg::EM_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (frm.start && state_r == crc8fr_pkg::EM_IDLE) begin
        idx_r <= '0;
      end else if (state_r == crc8fr_pkg::EM_SHOW && out_ready && !is_last) begin
        idx_r <= idx_r + crc8fr_pkg::STORE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frm.start && state_r == crc8fr_pkg::EM_IDLE) begin
      kind_r  <= frm.kind;
      len_r   <= frm.length;
      cnt_r   <= frm.count;
      empty_r <= (frm.count == '0);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crc8fr_pkg::EM_IDLE: begin
        if (frm.start) begin
          state_nxt = (frm.count == '0) ? crc8fr_pkg::EM_SHOW : crc8fr_pkg::EM_READ;
        end
      end
      crc8fr_pkg::EM_READ: state_nxt = crc8fr_pkg::EM_SHOW;
      crc8fr_pkg::EM_SHOW: begin
        if (out_ready) begin
          state_nxt = is_last ? crc8fr_pkg::EM_IDLE : crc8fr_pkg::EM_READ;
        end
      end
      default: state_nxt = crc8fr_pkg::EM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle             = (state_r == crc8fr_pkg::EM_IDLE);
    rd_en            = (state_r == crc8fr_pkg::EM_READ);
    rd_addr          = idx_r;
    out_valid        = (state_r == crc8fr_pkg::EM_SHOW);
    out_frame_type   = kind_r;
    out_frame_length = empty_r ? '0 : len_r;
    out_byte_index   = idx_r;
    out_payload_byte = empty_r ? '0 : rd_data;
    out_has_payload  = !empty_r;
    out_last         = is_last;
  end

`ifndef SYNTHESIS
  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frm.start |-> state_r == crc8fr_pkg::EM_IDLE)
    else $error("frame start while emitter busy");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frm.start |=> state_r != crc8fr_pkg::EM_IDLE)
    else $error("emitter ignored frame start");

  a_empty_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_payload) |-> (out_last && out_byte_index == '0))
    else $error("empty frame result malformed");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> state_r == crc8fr_pkg::EM_IDLE)
    else $error("emitter kept running after last item");
`endif

endmodule

### rtl/crc8_frame_receiver_core.sv
// Top level of the CRC-8 frame receiver: parser, payload store and emitter.
// Depends on crc8fr_pkg, crc8fr_parser, crc8fr_ram, crc8fr_emitter.
`timescale 1ns / 1ps
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    in_rx_byte
//  out_     output     out_valid/out_ready  frame_type, frame_length, byte_index,
//                                           payload_byte, has_payload, last
//  cfg_     input      cfg_we               cfg_index, cfg_wdata
//
//  One received byte is taken per cycle while no frame is being emitted.
//  A good frame is emitted item by item, each item a store read, then the output
//  register; an empty frame gives its one item in the cycle after the CRC byte.
//  The input is held off from the CRC byte until the last item goes.
//  Reset is synchronous; the payload store is not cleared.
//  A stalled output holds its item and keeps the input held off.

module crc8_frame_receiver_core #(
  parameter int MAX_PAYLOAD_BYTES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [crc8fr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crc8fr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [crc8fr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [crc8fr_pkg::BYTE_W-1:0]    out_frame_type,
  output logic [crc8fr_pkg::CNT_W-1:0]     out_frame_length,
  output logic [crc8fr_pkg::STORE_AW-1:0]  out_byte_index,
  output logic [crc8fr_pkg::BYTE_W-1:0]    out_payload_byte,
  output logic                             out_has_payload,
  output logic                             out_last
);

  crc8fr_pkg::frame_desc_t          frm;
  logic                             em_idle;
  logic                             in_fire;
  logic                             wr_en;
  logic [crc8fr_pkg::STORE_AW-1:0]  wr_addr;
  logic [crc8fr_pkg::BYTE_W-1:0]    wr_data;
  logic                             rd_en;
  logic [crc8fr_pkg::STORE_AW-1:0]  rd_addr;
  logic [crc8fr_pkg::BYTE_W-1:0]    rd_data;

  assign in_ready = em_idle;
  assign in_fire  = in_valid && in_ready;

  crc8fr_parser #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_rx_byte(in_rx_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .frm       (frm)
  );

  crc8fr_ram u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  crc8fr_emitter u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .frm             (frm),
    .idle            (em_idle),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_type  (out_frame_type),
    .out_frame_length(out_frame_length),
    .out_byte_index  (out_byte_index),
    .out_payload_byte(out_payload_byte),
    .out_has_payload (out_has_payload),
    .out_last        (out_last)
  );

endmodule
